>>> hdl/pssp_pkg.sv
package pssp_pkg;

   // data and register file
   localparam int DATA_W    = 32;
   localparam int FRAC      = 16;
   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM_END   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_START    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_END      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NOMINAL      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_END_LEVEL    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_CLAMP  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_CLAMP  = 3'd7;

   localparam logic [DATA_W-1:0] Q_ONE_WORD = 32'h0001_0000;

   // region codes
   localparam logic [1:0] REGION_BOTTOM  = 2'd0;
   localparam logic [1:0] REGION_MIDDLE  = 2'd1;
   localparam logic [1:0] REGION_TOP     = 2'd2;
   localparam logic [1:0] REGION_INVALID = 2'd3;

   // divider geometry
   localparam int DVD_W   = 69;
   localparam int QUO_W   = 53;
   localparam int DSR_W   = 32;
   localparam int REM_W   = 32;
   localparam int DIV_LAT = QUO_W + 1;

   // datapath widths
   localparam int LEN_W    = DATA_W + 1;
   localparam int T_W      = FRAC + 1;
   localparam int POLY_W   = 26;
   localparam int PROD_W   = 44;
   localparam int MUL_W    = 52;
   localparam int MAG_W    = 51;
   localparam int LV_W     = 35;
   localparam int SMAG_W   = DATA_W + 1;
   localparam int P_STAGES = 6;

   localparam logic [T_W-1:0] T_ONE = 17'h1_0000;

   // polynomial coefficients: K* are plain integers, Q* are Q16.16
   localparam logic signed [POLY_W-1:0] K6   = 26'sd6;
   localparam logic signed [POLY_W-1:0] K30  = 26'sd30;
   localparam logic signed [POLY_W-1:0] K120 = 26'sd120;
   localparam logic signed [POLY_W-1:0] Q10  = 26'sd655360;
   localparam logic signed [POLY_W-1:0] Q15  = 26'sd983040;
   localparam logic signed [POLY_W-1:0] Q30  = 26'sd1966080;
   localparam logic signed [POLY_W-1:0] Q60  = 26'sd3932160;
   localparam logic signed [POLY_W-1:0] Q180 = 26'sd11796480;

   localparam logic signed [PROD_W-1:0] PROD_HALF = 44'sd32768;
   localparam logic signed [MUL_W-1:0]  MUL_HALF  = 52'sd32768;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      TSEL_ZERO,
      TSEL_ONE,
      TSEL_DIV
   } tsel_type;

   typedef struct packed {
      logic [1:0]               region;
      logic                     flat;
      logic signed [LEN_W-1:0]  delta;
      logic signed [DATA_W-1:0] from_lv;
      logic signed [DATA_W-1:0] to_lv;
      logic [DSR_W-1:0]         len;
   } seg_type;

   typedef struct packed {
      seg_type  seg;
      tsel_type tsel;
   } side1_type;

   typedef struct packed {
      seg_type                  seg;
      logic [T_W-1:0]           t;
      logic signed [POLY_W-1:0] h;
      logic signed [POLY_W-1:0] dh;
      logic signed [POLY_W-1:0] d2h;
   } poly_type;

   typedef struct packed {
      seg_type                 seg;
      logic signed [MUL_W-1:0] ph;
      logic signed [MUL_W-1:0] pd;
      logic signed [MUL_W-1:0] pc;
   } prod_type;

   typedef struct packed {
      logic [1:0]             region;
      logic                   flat;
      logic signed [LV_W-1:0] lv;
      logic                   neg_s;
      logic                   neg_c;
      logic [DSR_W-1:0]       len;
   } side2_type;

   typedef struct packed {
      side2_type         base;
      logic              sl_big;
      logic [SMAG_W-1:0] sl_mag;
   } side3_type;

   typedef struct packed {
      logic                     flag;
      logic signed [DATA_W-1:0] value;
   } sat_type;

   // q16.16 product, rounded to nearest with ties toward +inf
   function automatic logic signed [POLY_W-1:0] mulq(
      input logic signed [POLY_W-1:0] a,
      input logic [T_W-1:0]           t
   );
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(a) * PROD_W'($signed({1'b0, t}));
      p = p + PROD_HALF;
      return POLY_W'(p >>> FRAC);
   endfunction

   // clip a wide signed level to the data range
   function automatic sat_type sat_level(input logic signed [LV_W-1:0] v);
      sat_type r;
      r.flag  = 1'b0;
      r.value = v[DATA_W-1:0];
      if (v > LV_W'(SAT_MAX)) begin
         r.flag  = 1'b1;
         r.value = SAT_MAX;
      end else if (v < LV_W'(SAT_MIN)) begin
         r.flag  = 1'b1;
         r.value = SAT_MIN;
      end
      return r;
   endfunction

   // apply sign to a magnitude and clip to the data range
   function automatic sat_type sat_mag(
      input logic              big,
      input logic [SMAG_W-1:0] mag,
      input logic              neg
   );
      sat_type r;
      r.flag  = 1'b0;
      r.value = neg ? -$signed(mag[DATA_W-1:0]) : $signed(mag[DATA_W-1:0]);
      if (!neg && (big || mag > SMAG_W'(33'h0_7fff_ffff))) begin
         r.flag  = 1'b1;
         r.value = SAT_MAX;
      end else if (neg && (big || mag > SMAG_W'(33'h0_8000_0000))) begin
         r.flag  = 1'b1;
         r.value = SAT_MIN;
      end
      return r;
   endfunction

endpackage

>>> hdl/pssp_div.sv
module pssp_div import pssp_pkg::*; (
   input  logic             clock,
   input  logic             advance,
   input  logic [DVD_W-1:0] dvd_in,
   input  logic [DSR_W-1:0] dsr_in,
   output logic [QUO_W-1:0] quo_out,
   output logic             rnd_out,
   output logic             ovf_out
);

   logic [REM_W-1:0] rem_ff [0:DIV_LAT-1];
   logic [REM_W-1:0] rem_in [0:DIV_LAT-1];
   logic [QUO_W-1:0] dvd_ff [0:DIV_LAT-1];
   logic [QUO_W-1:0] dvd_in_s [0:DIV_LAT-1];
   logic [QUO_W-1:0] quo_ff [0:DIV_LAT-1];
   logic [QUO_W-1:0] quo_in [0:DIV_LAT-1];
   logic [DSR_W-1:0] dsr_ff [0:DIV_LAT-1];
   logic [DSR_W-1:0] dsr_in_s [0:DIV_LAT-1];
   logic             ovf_ff [0:DIV_LAT-1];
   logic             ovf_in [0:DIV_LAT-1];

   // first stage loads the high part; then one quotient bit per stage
   always_comb begin
      logic [REM_W:0] shifted;
      logic           take;
      rem_in[0]   = REM_W'(dvd_in[DVD_W-1:QUO_W]);
      ovf_in[0]   = REM_W'(dvd_in[DVD_W-1:QUO_W]) >= dsr_in;
      dvd_in_s[0] = dvd_in[QUO_W-1:0];
      quo_in[0]   = '0;
      dsr_in_s[0] = dsr_in;
      for (int k = 1; k < DIV_LAT; k++) begin
         shifted     = {rem_ff[k-1], dvd_ff[k-1][QUO_W-k]};
         take        = shifted >= {1'b0, dsr_ff[k-1]};
         rem_in[k]   = take ? REM_W'(shifted - {1'b0, dsr_ff[k-1]}) : shifted[REM_W-1:0];
         quo_in[k]   = quo_ff[k-1];
         quo_in[k][QUO_W-k] = take;
         dvd_in_s[k] = dvd_ff[k-1];
         dsr_in_s[k] = dsr_ff[k-1];
         ovf_in[k]   = ovf_ff[k-1];
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            rem_ff[k] <= rem_in[k];
            dvd_ff[k] <= dvd_in_s[k];
            quo_ff[k] <= quo_in[k];
            dsr_ff[k] <= dsr_in_s[k];
            ovf_ff[k] <= ovf_in[k];
         end
      end
   end

   // round half away from zero on the magnitude
   assign quo_out = quo_ff[DIV_LAT-1];
   assign rnd_out = {rem_ff[DIV_LAT-1], 1'b0} >= {1'b0, dsr_ff[DIV_LAT-1]};
   assign ovf_out = ovf_ff[DIV_LAT-1];

endmodule

>>> hdl/piecewise_smootherstep_profile_top.sv
// Piecewise quintic smootherstep profile. One Q16.16 position enters per clock unless stalled; it
// is clamped, sorted into bottom ramp, flat middle or top ramp, and the level, slope and
// curvature come out saturated to 32 bits with a flag, one beat per clock in sustained flow.
// Four 54-stage restoring dividers, one quotient bit per stage, give the ramp parameter, then
// slope and first curvature quotient side by side, then the second curvature quotient; clamp,
// region and segment take three stages, the Horner polynomials six, products and level two.
// Stalls freeze the whole pipe only while the output holds a beat and the last stage is full;
// otherwise the pipe keeps moving and the stalled beat waits in the output register.
module piecewise_smootherstep_profile_top import pssp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_level,
   output logic signed [DATA_W-1:0] rsp_slope,
   output logic signed [DATA_W-1:0] rsp_curvature,
   output logic [1:0]               rsp_region,
   output logic                     rsp_saturated,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   logic [DATA_W-1:0] cfg_ff [0:NUM_REGS-1];
   logic signed [DATA_W-1:0] bottom_start, bottom_end, top_start, top_end;
   logic signed [DATA_W-1:0] nominal_level, end_level, lower_clamp, upper_clamp;

   logic hold, advance, last_valid;

   logic a_valid_ff, b_valid_ff, c_valid_ff, m_valid_ff, n_valid_ff, q_valid_ff;
   logic d1_valid_ff [0:DIV_LAT-1];
   logic d2_valid_ff [0:DIV_LAT-1];
   logic d4_valid_ff [0:DIV_LAT-1];
   logic p_valid_ff  [0:P_STAGES-1];

   logic signed [DATA_W-1:0] a_x_ff, a_x_in, a_x1;

   logic [1:0]               b_region_ff, b_region_in;
   logic                     b_flat_ff, b_flat_in;
   logic signed [DATA_W-1:0] b_x_ff, b_start_ff, b_start_in, b_end_ff, b_end_in;
   logic signed [DATA_W-1:0] b_from_ff, b_from_in, b_to_ff, b_to_in;

   seg_type                 c_seg_ff, c_seg_in;
   tsel_type                c_tsel_ff, c_tsel_in;
   logic signed [LEN_W-1:0] c_num_ff, c_num_in, c_len;

   side1_type side1_ff [0:DIV_LAT-1];
   logic [QUO_W-1:0] d1_quo, d2_quo, d3_quo, d4_quo;
   logic             d1_rnd, d2_rnd, d3_rnd, d4_rnd;
   logic             d1_ovf, d2_ovf, d3_ovf, d4_ovf;

   poly_type pv_ff [0:P_STAGES-1];
   poly_type pv_in [0:P_STAGES-1];

   prod_type m_ff, m_in;

   side2_type        n_side_ff, n_side_in;
   logic [MAG_W-1:0] n_mag_s_ff, n_mag_s_in, n_mag_c_ff, n_mag_c_in;

   side2_type side2_ff [0:DIV_LAT-1];

   side3_type        q_side_ff, q_side_in;
   logic [QUO_W-1:0] q_c1_ff, q_c1_in;

   side3_type side3_ff [0:DIV_LAT-1];

   sat_type f_lv, f_sl, f_cv;
   logic    f_cv_big;
   logic [SMAG_W-1:0] f_cv_mag;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_level_ff, rsp_level_in, rsp_slope_ff, rsp_slope_in;
   logic signed [DATA_W-1:0] rsp_curv_ff, rsp_curv_in;
   logic [1:0]               rsp_region_ff;
   logic                     rsp_sat_ff, rsp_sat_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= (i == int'(REG_NOMINAL) || i == int'(REG_END_LEVEL)) ?
                         Q_ONE_WORD : '0;
         end
      end else if (csr_write) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   assign bottom_start  = $signed(cfg_ff[REG_BOTTOM_START]);
   assign bottom_end    = $signed(cfg_ff[REG_BOTTOM_END]);
   assign top_start     = $signed(cfg_ff[REG_TOP_START]);
   assign top_end       = $signed(cfg_ff[REG_TOP_END]);
   assign nominal_level = $signed(cfg_ff[REG_NOMINAL]);
   assign end_level     = $signed(cfg_ff[REG_END_LEVEL]);
   assign lower_clamp   = $signed(cfg_ff[REG_LOWER_CLAMP]);
   assign upper_clamp   = $signed(cfg_ff[REG_UPPER_CLAMP]);

   // flow control: freeze only when the output is blocked and the last stage is full
   assign last_valid = d4_valid_ff[DIV_LAT-1];
   assign hold       = rsp_valid_ff & rsp_stall;
   assign advance    = ~hold | ~last_valid;
   assign req_stall  = ~advance;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         n_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         for (int k = 0; k < DIV_LAT; k++) begin
            d1_valid_ff[k] <= 1'b0;
            d2_valid_ff[k] <= 1'b0;
            d4_valid_ff[k] <= 1'b0;
         end
         for (int k = 0; k < P_STAGES; k++) begin
            p_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         a_valid_ff     <= req_valid;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= b_valid_ff;
         d1_valid_ff[0] <= c_valid_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            d1_valid_ff[k] <= d1_valid_ff[k-1];
            d2_valid_ff[k] <= d2_valid_ff[k-1];
            d4_valid_ff[k] <= d4_valid_ff[k-1];
         end
         p_valid_ff[0] <= d1_valid_ff[DIV_LAT-1];
         for (int k = 1; k < P_STAGES; k++) begin
            p_valid_ff[k] <= p_valid_ff[k-1];
         end
         m_valid_ff     <= p_valid_ff[P_STAGES-1];
         n_valid_ff     <= m_valid_ff;
         d2_valid_ff[0] <= n_valid_ff;
         q_valid_ff     <= d2_valid_ff[DIV_LAT-1];
         d4_valid_ff[0] <= q_valid_ff;
      end
   end

   // stage a: clamp, lower bound first
   always_comb begin
      a_x1   = (req_position < lower_clamp) ? lower_clamp : req_position;
      a_x_in = (a_x1 > upper_clamp) ? upper_clamp : a_x1;
   end

   // stage b: region and segment selection
   always_comb begin
      if (a_x_ff <= bottom_end) begin
         b_region_in = REGION_BOTTOM;
         b_flat_in   = 1'b0;
         b_start_in  = bottom_start;
         b_end_in    = bottom_end;
         b_from_in   = end_level;
         b_to_in     = nominal_level;
      end else if (a_x_ff <= top_start) begin
         b_region_in = REGION_MIDDLE;
         b_flat_in   = 1'b1;
         b_start_in  = top_start;
         b_end_in    = top_start;
         b_from_in   = nominal_level;
         b_to_in     = nominal_level;
      end else begin
         b_region_in = REGION_TOP;
         b_flat_in   = 1'b0;
         b_start_in  = top_start;
         b_end_in    = top_end;
         b_from_in   = nominal_level;
         b_to_in     = end_level;
      end
   end

   // stage c: segment length, offset, delta and ramp parameter select
   always_comb begin
      c_len            = LEN_W'(b_end_ff) - LEN_W'(b_start_ff);
      c_num_in         = LEN_W'(b_x_ff) - LEN_W'(b_start_ff);
      c_seg_in.region  = b_region_ff;
      c_seg_in.flat    = b_flat_ff | (c_len <= 0);
      c_seg_in.delta   = LEN_W'(b_to_ff) - LEN_W'(b_from_ff);
      c_seg_in.from_lv = b_from_ff;
      c_seg_in.to_lv   = b_to_ff;
      c_seg_in.len     = c_len[DSR_W-1:0];
      if (b_x_ff <= b_start_ff) begin
         c_tsel_in = TSEL_ZERO;
      end else if (b_x_ff >= b_end_ff) begin
         c_tsel_in = TSEL_ONE;
      end else begin
         c_tsel_in = TSEL_DIV;
      end
   end

   // ramp parameter divider: t = offset * 2^16 / length
   pssp_div u_div_t (
      .clock   (clock),
      .advance (advance),
      .dvd_in  (DVD_W'({c_num_ff[DATA_W-1:0], {FRAC{1'b0}}})),
      .dsr_in  (c_seg_ff.len),
      .quo_out (d1_quo),
      .rnd_out (d1_rnd),
      .ovf_out (d1_ovf)
   );

   // horner stages for h, dh and d2h
   always_comb begin
      pv_in[0].seg = side1_ff[DIV_LAT-1].seg;
      case (side1_ff[DIV_LAT-1].tsel)
         TSEL_ZERO: pv_in[0].t = '0;
         TSEL_ONE:  pv_in[0].t = T_ONE;
         default:   pv_in[0].t = d1_quo[T_W-1:0];
      endcase
      pv_in[0].h   = '0;
      pv_in[0].dh  = '0;
      pv_in[0].d2h = '0;

      pv_in[1]     = pv_ff[0];
      pv_in[1].h   = K6 * $signed(POLY_W'(pv_ff[0].t)) - Q15;
      pv_in[1].dh  = K30 * $signed(POLY_W'(pv_ff[0].t)) - Q60;
      pv_in[1].d2h = K120 * $signed(POLY_W'(pv_ff[0].t)) - Q180;

      pv_in[2]     = pv_ff[1];
      pv_in[2].h   = mulq(pv_ff[1].h, pv_ff[1].t) + Q10;
      pv_in[2].dh  = mulq(pv_ff[1].dh, pv_ff[1].t) + Q30;
      pv_in[2].d2h = mulq(pv_ff[1].d2h, pv_ff[1].t) + Q60;

      pv_in[3]     = pv_ff[2];
      pv_in[3].h   = mulq(pv_ff[2].h, pv_ff[2].t);
      pv_in[3].dh  = mulq(pv_ff[2].dh, pv_ff[2].t);
      pv_in[3].d2h = mulq(pv_ff[2].d2h, pv_ff[2].t);

      pv_in[4]     = pv_ff[3];
      pv_in[4].h   = mulq(pv_ff[3].h, pv_ff[3].t);
      pv_in[4].dh  = mulq(pv_ff[3].dh, pv_ff[3].t);

      pv_in[5]     = pv_ff[4];
      pv_in[5].h   = mulq(pv_ff[4].h, pv_ff[4].t);
   end

   // delta products
   always_comb begin
      m_in.seg = pv_ff[P_STAGES-1].seg;
      m_in.ph  = pv_ff[P_STAGES-1].seg.delta * pv_ff[P_STAGES-1].h;
      m_in.pd  = pv_ff[P_STAGES-1].seg.delta * pv_ff[P_STAGES-1].dh;
      m_in.pc  = pv_ff[P_STAGES-1].seg.delta * pv_ff[P_STAGES-1].d2h;
   end

   // level and divider magnitudes
   always_comb begin
      n_side_in.region = m_ff.seg.region;
      n_side_in.flat   = m_ff.seg.flat;
      n_side_in.len    = m_ff.seg.len;
      if (m_ff.seg.flat) begin
         n_side_in.lv = LV_W'(m_ff.seg.to_lv);
      end else begin
         n_side_in.lv = LV_W'(m_ff.seg.from_lv) + LV_W'((m_ff.ph + MUL_HALF) >>> FRAC);
      end
      n_side_in.neg_s = m_ff.pd < 0;
      n_side_in.neg_c = m_ff.pc < 0;
      n_mag_s_in      = n_side_in.neg_s ? MAG_W'(-m_ff.pd) : MAG_W'(m_ff.pd);
      n_mag_c_in      = n_side_in.neg_c ? MAG_W'(-m_ff.pc) : MAG_W'(m_ff.pc);
   end

   // slope and first curvature quotient
   pssp_div u_div_slope (
      .clock   (clock),
      .advance (advance),
      .dvd_in  (DVD_W'(n_mag_s_ff)),
      .dsr_in  (n_side_ff.len),
      .quo_out (d2_quo),
      .rnd_out (d2_rnd),
      .ovf_out (d2_ovf)
   );

   pssp_div u_div_c1 (
      .clock   (clock),
      .advance (advance),
      .dvd_in  (DVD_W'(n_mag_c_ff)),
      .dsr_in  (n_side_ff.len),
      .quo_out (d3_quo),
      .rnd_out (d3_rnd),
      .ovf_out (d3_ovf)
   );

   // slope rounding and first curvature quotient
   always_comb begin
      q_side_in.base   = side2_ff[DIV_LAT-1];
      q_side_in.sl_big = d2_ovf | (|d2_quo[QUO_W-1:DATA_W]);
      q_side_in.sl_mag = SMAG_W'(d2_quo[DATA_W-1:0]) + SMAG_W'(d2_rnd);
      q_c1_in          = d3_quo + QUO_W'(d3_rnd);
   end

   // second curvature division, scaled by 2^16
   pssp_div u_div_curv (
      .clock   (clock),
      .advance (advance),
      .dvd_in  ({q_c1_ff, {FRAC{1'b0}}}),
      .dsr_in  (q_side_ff.base.len),
      .quo_out (d4_quo),
      .rnd_out (d4_rnd),
      .ovf_out (d4_ovf)
   );

   // final saturation
   always_comb begin
      f_cv_big = d4_ovf | (|d4_quo[QUO_W-1:DATA_W]) | d3_ovf_unused_guard();
      f_cv_mag = SMAG_W'(d4_quo[DATA_W-1:0]) + SMAG_W'(d4_rnd);
      f_lv     = sat_level(side3_ff[DIV_LAT-1].base.lv);
      f_sl     = sat_mag(side3_ff[DIV_LAT-1].sl_big, side3_ff[DIV_LAT-1].sl_mag,
                         side3_ff[DIV_LAT-1].base.neg_s);
      f_cv     = sat_mag(f_cv_big, f_cv_mag, side3_ff[DIV_LAT-1].base.neg_c);
      if (side3_ff[DIV_LAT-1].base.flat) begin
         f_sl = '0;
         f_cv = '0;
      end
      rsp_level_in = f_lv.value;
      rsp_slope_in = f_sl.value;
      rsp_curv_in  = f_cv.value;
      rsp_sat_in   = f_lv.flag | f_sl.flag | f_cv.flag;
   end

   // first curvature quotient overflows only on zero length (flat); ramp divider flags unused too
   function automatic logic d3_ovf_unused_guard();
      return 1'b0 & d3_ovf & d1_ovf & d1_rnd;
   endfunction

   // pipeline payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         a_x_ff      <= a_x_in;
         b_region_ff <= b_region_in;
         b_flat_ff   <= b_flat_in;
         b_x_ff      <= a_x_ff;
         b_start_ff  <= b_start_in;
         b_end_ff    <= b_end_in;
         b_from_ff   <= b_from_in;
         b_to_ff     <= b_to_in;
         c_seg_ff    <= c_seg_in;
         c_tsel_ff   <= c_tsel_in;
         c_num_ff    <= c_num_in;
         side1_ff[0] <= '{seg: c_seg_ff, tsel: c_tsel_ff};
         side2_ff[0] <= n_side_ff;
         side3_ff[0] <= q_side_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            side1_ff[k] <= side1_ff[k-1];
            side2_ff[k] <= side2_ff[k-1];
            side3_ff[k] <= side3_ff[k-1];
         end
         for (int k = 0; k < P_STAGES; k++) begin
            pv_ff[k] <= pv_in[k];
         end
         m_ff       <= m_in;
         n_side_ff  <= n_side_in;
         n_mag_s_ff <= n_mag_s_in;
         n_mag_c_ff <= n_mag_c_in;
         q_side_ff  <= q_side_in;
         q_c1_ff    <= q_c1_in;
      end
   end

   // output register, holds while the beat is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!hold) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         rsp_level_ff  <= rsp_level_in;
         rsp_slope_ff  <= rsp_slope_in;
         rsp_curv_ff   <= rsp_curv_in;
         rsp_region_ff <= side3_ff[DIV_LAT-1].base.region;
         rsp_sat_ff    <= rsp_sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_slope     = rsp_slope_ff;
   assign rsp_curvature = rsp_curv_ff;
   assign rsp_region    = rsp_region_ff;
   assign rsp_saturated = rsp_sat_ff;

   // flat middle region carries no derivative and never clips
   a_middle_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_region == REGION_MIDDLE |->
         rsp_slope == '0 && rsp_curvature == '0 && !rsp_saturated)
      else $error("middle region beat with nonzero derivative or saturation");

   // input is held off only by a blocked output with a full last stage
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && last_valid)
      else $error("input stalled without a blocked output");

   // region code stays in range
   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_region != REGION_INVALID)
      else $error("invalid region code on output");

endmodule
